// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL file edf_deadline_scheduler.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== sv/edf_pkg.sv =====
package edf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W = 5;
    localparam int WORKER_W = 2;
    localparam logic [31:0] TIM_DEV = 32'd1;

    localparam logic OP_RELEASE = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    typedef struct packed {
        logic valid;
        logic [31:0] deadline;
        logic [31:0] id;
        logic [WORKER_W-1:0] worker;
    } entry_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SHIFT,
        CMD_CMP_DL,
        CMD_CMP_ID,
        CMD_INSERT,
        CMD_REMOVE
    } cell_cmd_t;

endpackage

// ===== sv/edf_cell.sv =====
module edf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  edf_pkg::cell_cmd_t cmd,
    input  logic [31:0]       key_deadline,
    input  logic [31:0]       key_id,
    input  edf_pkg::entry_t   new_entry,
    input  edf_pkg::entry_t   left_entry,
    input  logic              left_flag,
    input  edf_pkg::entry_t   right_entry,
    input  logic              hit_in,
    output edf_pkg::entry_t   entry,
    output logic              flag,
    output logic              hit_out
);
    import edf_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   flag_reg;
    logic   flag_next;

    assign entry = entry_reg;
    assign flag = flag_reg;
    assign hit_out = hit_in | flag_reg;

    always_comb
    begin
        entry_next = entry_reg;
        flag_next = flag_reg;
        case (cmd)
            CMD_SHIFT:
            begin
                entry_next = right_entry;
            end
            CMD_CMP_DL:
            begin
                flag_next = !entry_reg.valid || (key_deadline < entry_reg.deadline);
            end
            CMD_CMP_ID:
            begin
                flag_next = entry_reg.valid && (entry_reg.id == key_id);
            end
            CMD_INSERT:
            begin
                if (left_flag)
                begin
                    entry_next = left_entry;
                end
                else if (flag_reg)
                begin
                    entry_next = new_entry;
                end
            end
            CMD_REMOVE:
            begin
                if (hit_out)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            flag_reg <= flag_next;
        end
    end

endmodule

// ===== sv/edf_deadline_scheduler.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  op, task_id, worker, deadline, now
// output    out        out_valid / out_stall dispatch_*, preempt_*, expired_count,
//                                           complete_found, completion_tick, table_full
// A release steps through S_EXPIRE, which drops overdue entries, S_CMP, S_UPDATE,
// S_RUNCMP and S_DISPATCH; a completion skips S_EXPIRE.
// The next input transfer can be taken in the cycle the result is ready.
// Overdue entries leave the cell chain one per cycle from its head.
// A new item is taken while a finished result waits in the output register.
// The last step waits while the output register is full and stalled.
// Reset empties the table and clears the running task at once.
module edf_deadline_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] task_id,
    input  logic [1:0]  worker,
    input  logic [31:0] deadline,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        dispatch_valid,
    output logic [31:0] dispatch_task_id,
    output logic [1:0]  dispatch_worker,
    output logic        preempt_valid,
    output logic [1:0]  preempt_worker,
    output logic [4:0]  expired_count,
    output logic        complete_found,
    output logic [31:0] completion_tick,
    output logic        table_full
);
    import edf_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPIRE,
        S_CMP,
        S_UPDATE,
        S_RUNCMP,
        S_DISPATCH
    } state_t;

    state_t state_reg;
    logic op_reg;
    logic [31:0] tid_reg;
    logic [WORKER_W-1:0] wrk_reg;
    logic [31:0] dl_reg;
    logic [31:0] now_reg;
    logic [CNT_W-1:0] expired_reg;
    logic found_reg;
    logic full_reg;
    logic running_valid_reg;
    logic [31:0] running_id_reg;

    logic out_valid_reg;
    logic dispatch_valid_reg;
    logic [31:0] dispatch_task_id_reg;
    logic [WORKER_W-1:0] dispatch_worker_reg;
    logic preempt_valid_reg;
    logic [WORKER_W-1:0] preempt_worker_reg;
    logic [CNT_W-1:0] expired_count_reg;
    logic complete_found_reg;
    logic [31:0] completion_tick_reg;
    logic table_full_reg;

    cell_cmd_t cmd;
    logic [31:0] key_id;
    entry_t new_entry;
    entry_t empty_entry;
    entry_t cells [TABLE_DEPTH];
    logic flags [TABLE_DEPTH];
    logic hits [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;

    logic head_expired;
    logic run_found;
    entry_t run_entry;
    logic out_free;

    assign new_entry = '{valid: 1'b1, deadline: dl_reg, id: tid_reg, worker: wrk_reg};
    assign empty_entry = '0;
    assign key_id = (state_reg == S_RUNCMP) ? running_id_reg : tid_reg;
    assign head_expired = cells[0].valid && (cells[0].deadline < now_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd = CMD_HOLD;
        case (state_reg)
            S_EXPIRE:
            begin
                if (head_expired)
                begin
                    cmd = CMD_SHIFT;
                end
            end
            S_CMP:
            begin
                cmd = (op_reg == OP_RELEASE) ? CMD_CMP_DL : CMD_CMP_ID;
            end
            S_UPDATE:
            begin
                if (op_reg == OP_RELEASE)
                begin
                    if (!cells[TABLE_DEPTH-1].valid)
                    begin
                        cmd = CMD_INSERT;
                    end
                end
                else if (hits[TABLE_DEPTH-1])
                begin
                    cmd = CMD_REMOVE;
                end
            end
            S_RUNCMP:
            begin
                cmd = CMD_CMP_ID;
            end
            default:
            begin
                cmd = CMD_HOLD;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic left_f;
            logic hit_i;
            if (g == 0)
            begin : g_first
                assign left_e = empty_entry;
                assign left_f = 1'b0;
                assign hit_i = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cells[g-1];
                assign left_f = flags[g-1];
                assign hit_i = hits[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign right_e = empty_entry;
            end
            else
            begin : g_inner
                assign right_e = cells[g+1];
            end
            edf_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .key_deadline (dl_reg),
                .key_id       (key_id),
                .new_entry    (new_entry),
                .left_entry   (left_e),
                .left_flag    (left_f),
                .right_entry  (right_e),
                .hit_in       (hit_i),
                .entry        (cells[g]),
                .flag         (flags[g]),
                .hit_out      (hits[g])
            );
            assign valid_vec[g] = cells[g].valid;
        end
    endgenerate

    always_comb
    begin
        run_found = 1'b0;
        run_entry = empty_entry;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (flags[i])
            begin
                run_found = 1'b1;
                run_entry = cells[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_RELEASE;
            tid_reg <= '0;
            wrk_reg <= '0;
            dl_reg <= '0;
            now_reg <= '0;
            expired_reg <= '0;
            found_reg <= 1'b0;
            full_reg <= 1'b0;
            running_valid_reg <= 1'b0;
            running_id_reg <= '0;
            out_valid_reg <= 1'b0;
            dispatch_valid_reg <= 1'b0;
            dispatch_task_id_reg <= '0;
            dispatch_worker_reg <= '0;
            preempt_valid_reg <= 1'b0;
            preempt_worker_reg <= '0;
            expired_count_reg <= '0;
            complete_found_reg <= 1'b0;
            completion_tick_reg <= '0;
            table_full_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_DISPATCH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= op;
                        tid_reg <= task_id;
                        wrk_reg <= worker;
                        dl_reg <= deadline;
                        now_reg <= now;
                        expired_reg <= '0;
                        found_reg <= 1'b0;
                        full_reg <= 1'b0;
                        state_reg <= (op == OP_RELEASE) ? S_EXPIRE : S_CMP;
                    end
                end
                S_EXPIRE:
                begin
                    if (head_expired)
                    begin
                        expired_reg <= expired_reg + CNT_W'(1);
                        if (running_valid_reg && (cells[0].id == running_id_reg))
                        begin
                            running_valid_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (op_reg == OP_RELEASE)
                    begin
                        full_reg <= cells[TABLE_DEPTH-1].valid;
                    end
                    else if (hits[TABLE_DEPTH-1])
                    begin
                        found_reg <= 1'b1;
                        if (running_valid_reg && (tid_reg == running_id_reg))
                        begin
                            running_valid_reg <= 1'b0;
                        end
                    end
                    state_reg <= S_RUNCMP;
                end
                S_RUNCMP:
                begin
                    state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    if (out_free)
                    begin
                        dispatch_valid_reg <= 1'b0;
                        dispatch_task_id_reg <= '0;
                        dispatch_worker_reg <= '0;
                        preempt_valid_reg <= 1'b0;
                        preempt_worker_reg <= '0;
                        if (cells[0].valid)
                        begin
                            if (running_valid_reg && run_found
                                && !(cells[0].deadline < run_entry.deadline))
                            begin
                                dispatch_valid_reg <= 1'b0;
                            end
                            else
                            begin
                                if (running_valid_reg && run_found)
                                begin
                                    preempt_valid_reg <= 1'b1;
                                    preempt_worker_reg <= run_entry.worker;
                                end
                                dispatch_valid_reg <= 1'b1;
                                dispatch_task_id_reg <= cells[0].id;
                                dispatch_worker_reg <= cells[0].worker;
                                running_valid_reg <= 1'b1;
                                running_id_reg <= cells[0].id;
                            end
                        end
                        expired_count_reg <= expired_reg;
                        complete_found_reg <= found_reg;
                        completion_tick_reg <= found_reg ? (now_reg - TIM_DEV) : 32'd0;
                        table_full_reg <= full_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign dispatch_valid = dispatch_valid_reg;
    assign dispatch_task_id = dispatch_task_id_reg;
    assign dispatch_worker = dispatch_worker_reg;
    assign preempt_valid = preempt_valid_reg;
    assign preempt_worker = preempt_worker_reg;
    assign expired_count = expired_count_reg;
    assign complete_found = complete_found_reg;
    assign completion_tick = completion_tick_reg;
    assign table_full = table_full_reg;

    `ASSERT_NEVER(a_valid_packed, clk, rst_n, ((valid_vec >> 1) & ~valid_vec) != '0)
    `ASSERT_CLK(a_running_in_table, clk, rst_n, (state_reg == S_IDLE && running_valid_reg) |-> (valid_vec != '0))
    `ASSERT_CLK(a_complete_no_expiry, clk, rst_n, (out_valid_reg && complete_found_reg) |-> (expired_count_reg == '0 && !table_full_reg))

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import edf_pkg::*;

    typedef struct packed {
        logic        d_valid;
        logic [31:0] d_id;
        logic [1:0]  d_worker;
        logic        p_valid;
        logic [1:0]  p_worker;
        logic [4:0]  expired;
        logic        found;
        logic [31:0] ctick;
        logic        full;
    } sched_result_t;

    class sched_scoreboard;
        logic [31:0] tab_dl [TABLE_DEPTH];
        logic [31:0] tab_id [TABLE_DEPTH];
        logic [1:0]  tab_wk [TABLE_DEPTH];
        int          tab_n;
        bit          run_v;
        logic [31:0] run_id;
        sched_result_t pending [$];
        int          errors;

        function void clear();
            tab_n = 0;
            run_v = 0;
            run_id = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void note_transfer(logic o, logic [31:0] tid, logic [1:0] wk,
                                    logic [31:0] dl, logic [31:0] tnow);
            sched_result_t r;
            int i, j, pos;
            r = '0;
            if (o == OP_RELEASE) begin
                j = 0;
                for (i = 0; i < tab_n; i++) begin
                    if (tab_dl[i] < tnow) begin
                        if (r.expired < 31) r.expired++;
                        if (run_v && tab_id[i] == run_id) run_v = 0;
                    end else begin
                        tab_dl[j] = tab_dl[i];
                        tab_id[j] = tab_id[i];
                        tab_wk[j] = tab_wk[i];
                        j++;
                    end
                end
                tab_n = j;
                if (tab_n >= TABLE_DEPTH) begin
                    r.full = 1;
                end else begin
                    pos = 0;
                    while (pos < tab_n && !(dl < tab_dl[pos])) pos++;
                    for (i = tab_n; i > pos; i--) begin
                        tab_dl[i] = tab_dl[i-1];
                        tab_id[i] = tab_id[i-1];
                        tab_wk[i] = tab_wk[i-1];
                    end
                    tab_dl[pos] = dl;
                    tab_id[pos] = tid;
                    tab_wk[pos] = wk;
                    tab_n++;
                end
            end else begin
                for (i = 0; i < tab_n; i++)
                    if (tab_id[i] == tid) break;
                if (i < tab_n) begin
                    for (j = i; j + 1 < tab_n; j++) begin
                        tab_dl[j] = tab_dl[j+1];
                        tab_id[j] = tab_id[j+1];
                        tab_wk[j] = tab_wk[j+1];
                    end
                    tab_n--;
                    r.found = 1;
                    r.ctick = tnow - TIM_DEV;
                    if (run_v && tid == run_id) run_v = 0;
                end
            end
            if (tab_n > 0) begin
                bit give;
                give = 1;
                if (run_v) begin
                    for (i = 0; i < tab_n; i++)
                        if (tab_id[i] == run_id) break;
                    if (i < tab_n) begin
                        if (tab_dl[0] < tab_dl[i]) begin
                            r.p_valid = 1;
                            r.p_worker = tab_wk[i];
                        end else begin
                            give = 0;
                        end
                    end
                end
                if (give) begin
                    r.d_valid = 1;
                    r.d_id = tab_id[0];
                    r.d_worker = tab_wk[0];
                    run_v = 1;
                    run_id = tab_id[0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(sched_result_t a);
            sched_result_t e;
            if (pending.size() == 0) begin
                $error("result transfer with no expectation");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.d_valid !== e.d_valid) begin
                $error("dispatch_valid exp %0h got %0h", e.d_valid, a.d_valid); errors++;
            end
            if (a.d_id !== e.d_id) begin
                $error("dispatch_task_id exp %0h got %0h", e.d_id, a.d_id); errors++;
            end
            if (a.d_worker !== e.d_worker) begin
                $error("dispatch_worker exp %0h got %0h", e.d_worker, a.d_worker); errors++;
            end
            if (a.p_valid !== e.p_valid) begin
                $error("preempt_valid exp %0h got %0h", e.p_valid, a.p_valid); errors++;
            end
            if (a.p_worker !== e.p_worker) begin
                $error("preempt_worker exp %0h got %0h", e.p_worker, a.p_worker); errors++;
            end
            if (a.expired !== e.expired) begin
                $error("expired_count exp %0h got %0h", e.expired, a.expired); errors++;
            end
            if (a.found !== e.found) begin
                $error("complete_found exp %0h got %0h", e.found, a.found); errors++;
            end
            if (a.ctick !== e.ctick) begin
                $error("completion_tick exp %0h got %0h", e.ctick, a.ctick); errors++;
            end
            if (a.full !== e.full) begin
                $error("table_full exp %0h got %0h", e.full, a.full); errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        op = 0;
    logic [31:0] task_id = 0;
    logic [1:0]  worker = 0;
    logic [31:0] deadline = 0;
    logic [31:0] now = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        dispatch_valid;
    logic [31:0] dispatch_task_id;
    logic [1:0]  dispatch_worker;
    logic        preempt_valid;
    logic [1:0]  preempt_worker;
    logic [4:0]  expired_count;
    logic        complete_found;
    logic [31:0] completion_tick;
    logic        table_full;

    sched_scoreboard sb;
    int          idle_cycles = 0;
    bit          hold_long;
    logic [31:0] tick;
    logic [31:0] recent_ids [8];

    edf_deadline_scheduler u_top (.*);

    always #2 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_item(logic o, logic [31:0] tid, logic [1:0] wk,
                             logic [31:0] dl, logic [31:0] tnow);
        op <= o;
        task_id <= tid;
        worker <= wk;
        deadline <= dl;
        now <= tnow;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        sb.note_transfer(o, tid, wk, dl, tnow);
        if (o == OP_RELEASE) recent_ids[$urandom_range(0, 7)] = tid;
    endtask

    task automatic pause_src(int n);
        if (n > 0) begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [31:0] tid;
        logic [31:0] dl;
        logic        o;
        o = ($urandom_range(0, 9) < 4) ? OP_COMPLETE : OP_RELEASE;
        tid = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20);
        if (o == OP_COMPLETE && $urandom_range(0, 2) != 0)
            tid = recent_ids[$urandom_range(0, 7)];
        if ($urandom_range(0, 15) == 0) tick = $urandom();
        else tick = tick + $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) dl = $urandom();
        else dl = tick + $urandom_range(0, 40) - 4;
        send_item(o, tid, $urandom_range(0, 3), dl, tick);
        pause_src(gap_len());
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sched_result_t a;
            a = {dispatch_valid, dispatch_task_id, dispatch_worker, preempt_valid,
                 preempt_worker, expired_count, complete_found, completion_tick,
                 table_full};
            sb.check_result(a);
        end
    end

    initial begin
        int n;
        repeat (6) @(posedge clk);
        while (1) begin
            if (hold_long) begin
                out_stall <= 1;
                repeat (200) @(posedge clk);
                hold_long = 0;
            end
            n = gap_len();
            if (n > 0) begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("** edf_deadline_scheduler: FAILED **");
            $finish;
        end
    end

    initial begin
        int i;
        sb = new();
        sb.clear();
        hold_long = 0;
        tick = 100;
        for (i = 0; i < 8; i++) recent_ids[i] = i;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_item(OP_COMPLETE, 32'd5, 2'd0, 32'd0, 32'd0);
        send_item(OP_RELEASE, 32'hFFFFFFFF, 2'd3, 32'hFFFFFFFF, 32'd0);
        send_item(OP_RELEASE, 32'd1, 2'd1, 32'd50, 32'd0);
        send_item(OP_RELEASE, 32'd2, 2'd2, 32'd50, 32'd0);
        send_item(OP_RELEASE, 32'd1, 2'd0, 32'd60, 32'd0);
        send_item(OP_COMPLETE, 32'd1, 2'd3, 32'hFFFFFFFF, 32'd0);
        send_item(OP_COMPLETE, 32'd2, 2'd0, 32'd0, 32'd70);
        for (i = 0; i < 16; i++)
            send_item(OP_RELEASE, 32'd100 + i, i[1:0], 32'd200 - i, 32'd60);
        send_item(OP_RELEASE, 32'd999, 2'd1, 32'd1, 32'd60);
        send_item(OP_RELEASE, 32'd7, 2'd2, 32'd0, 32'd195);
        send_item(OP_RELEASE, 32'd8, 2'd1, 32'd0, 32'hFFFFFFFF);
        send_item(OP_COMPLETE, 32'd8, 2'd0, 32'd0, 32'd0);
        wait_drained();
        hold_long = 1;
        for (i = 0; i < 40; i++) send_item(OP_RELEASE, $urandom_range(0, 9),
                                           $urandom_range(0, 3), tick + i, tick);
        wait_drained();
        for (i = 0; i < 450; i++) begin
            send_random();
            if (i == 200) wait_drained();
        end
        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** edf_deadline_scheduler: PASSED **");
        else
            $display("** edf_deadline_scheduler: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/edf_pkg.sv
sv/edf_cell.sv
sv/edf_deadline_scheduler.sv
verif/tb.sv
